FILE: rtl/esn_pkg.sv
package esn_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] REG_MEMBRANE_DECAY   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPT_DECAY      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADAPT_STEP       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_RATE_GAIN = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_RATE_GAIN    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_SLOPE        = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_STEPS       = 4'd7;

    localparam logic [17:0] LOG2E_Q16    = 18'd94548;
    localparam logic [46:0] SAT_Q32      = 47'h4000_0000_0000;
    localparam logic [31:0] RECIP_Q41    = 32'd2199023255;  // floor(2^41 / 1000)
    localparam logic [17:0] RECIP_Q27    = 18'd134218;      // ceil(2^27 / 1000)
    localparam logic [36:0] SMALL_LAMBDA = 37'd67108864;

    typedef struct packed {
        logic signed [15:0] syn_jump;
        logic signed [23:0] input_current;
        logic        [15:0] random_uniform;
    } item_t;

    typedef struct packed {
        logic               spike;
        logic signed [15:0] membrane_potential;
        logic signed [15:0] adapt_level;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mul_i;
        logic pot;
        logic adp;
        logic lin;
        logic expx;
        logic expy;
        logic expm;
        logic expp;
        logic exps;
        logic div1;
        logic div2;
        logic div3;
        logic prb1;
        logic prb2;
        logic prb3;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic dead_zero;
        logic rate_pos;
        logic lam_small;
        logic out_busy;
    } status_t;

    function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
        if (v > 50'sd32767)
            return 16'sh7fff;
        else if (v < -50'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    // 2^(i/16) in Q.16
    function automatic logic [17:0] pow2_tab(input logic [4:0] i);
        logic [17:0] v;
        case (i)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

    // mantissa of 2^f for a 20 bit fraction, Q.32
    function automatic logic [32:0] pow2_mant(input logic [19:0] f);
        logic [17:0] lo;
        logic [17:0] hi;
        logic [12:0] d;
        lo = pow2_tab({1'b0, f[19:16]});
        hi = pow2_tab({1'b0, f[19:16]} + 5'd1);
        d  = 13'(hi - lo);
        return {lo[16:0], 16'b0} + 33'(33'(d) * 33'(f[15:0]));
    endfunction

endpackage

FILE: rtl/esn_ifs.sv
interface esn_item_if;
    import esn_pkg::*;
    logic  valid;
    logic  ready;
    item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface esn_result_if;
    import esn_pkg::*;
    logic    valid;
    logic    ready;
    result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface esn_cfg_if;
    import esn_pkg::*;
    logic valid;
    logic ready;
    cfg_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/esn_ctrl.sv
module esn_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  esn_pkg::status_t status,
    output esn_pkg::cmd_t    cmd
);
    import esn_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE = 17'b00000000000000001,
        S_MULI = 17'b00000000000000010,
        S_POT  = 17'b00000000000000100,
        S_ADP  = 17'b00000000000001000,
        S_LIN  = 17'b00000000000010000,
        S_EXPX = 17'b00000000000100000,
        S_EXPY = 17'b00000000001000000,
        S_EXPM = 17'b00000000010000000,
        S_EXPP = 17'b00000000100000000,
        S_EXPS = 17'b00000001000000000,
        S_DIV1 = 17'b00000010000000000,
        S_DIV2 = 17'b00000100000000000,
        S_DIV3 = 17'b00001000000000000,
        S_PRB1 = 17'b00010000000000000,
        S_PRB2 = 17'b00100000000000000,
        S_PRB3 = 17'b01000000000000000,
        S_FIN  = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MULI;
                end
            end
            S_MULI:
            begin
                cmd.mul_i  = 1'b1;
                state_next = S_POT;
            end
            S_POT:
            begin
                cmd.pot    = 1'b1;
                state_next = S_ADP;
            end
            S_ADP:
            begin
                cmd.adp    = 1'b1;
                state_next = status.dead_zero ? S_LIN : S_FIN;
            end
            S_LIN:
            begin
                cmd.lin    = 1'b1;
                state_next = S_EXPX;
            end
            S_EXPX:
            begin
                cmd.expx   = 1'b1;
                state_next = S_EXPY;
            end
            S_EXPY:
            begin
                cmd.expy   = 1'b1;
                state_next = S_EXPM;
            end
            S_EXPM:
            begin
                cmd.expm   = 1'b1;
                state_next = S_EXPP;
            end
            S_EXPP:
            begin
                cmd.expp   = 1'b1;
                state_next = S_EXPS;
            end
            S_EXPS:
            begin
                cmd.exps   = 1'b1;
                state_next = status.rate_pos ? S_DIV1 : S_FIN;
            end
            S_DIV1:
            begin
                cmd.div1   = 1'b1;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.div2   = 1'b1;
                state_next = S_DIV3;
            end
            S_DIV3:
            begin
                cmd.div3   = 1'b1;
                state_next = S_PRB1;
            end
            S_PRB1:
            begin
                cmd.prb1   = 1'b1;
                state_next = status.lam_small ? S_PRB3 : S_PRB2;
            end
            S_PRB2:
            begin
                cmd.prb2   = 1'b1;
                state_next = S_PRB3;
            end
            S_PRB3:
            begin
                cmd.prb3   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/esn_datapath.sv
module esn_datapath #(
    parameter bit RESET_ON_SPIKE = 1'b1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  esn_pkg::cmd_t   cmd,
    output esn_pkg::status_t status,
    input  esn_pkg::item_t  item_payload,
    esn_cfg_if.sink         cfg,
    esn_result_if.source    result
);
    import esn_pkg::*;

    // configuration
    logic        [15:0] md_reg, md_next;
    logic        [23:0] ig_reg, ig_next;
    logic        [15:0] ad_reg, ad_next;
    logic signed [15:0] astep_reg, astep_next;
    logic signed [15:0] lrg_reg, lrg_next;
    logic        [15:0] erg_reg, erg_next;
    logic        [15:0] slope_reg, slope_next;
    logic        [15:0] dsteps_reg, dsteps_next;

    // neuron state
    logic signed [15:0] pot_reg, pot_next;
    logic signed [15:0] adp_reg, adp_next;
    logic signed [23:0] held_reg, held_next;
    logic        [15:0] dead_reg, dead_next;

    // working registers
    logic signed [15:0] jump_reg, jump_next;
    logic signed [23:0] cur_reg, cur_next;
    logic        [15:0] rnd_reg, rnd_next;
    logic signed [48:0] prod_i_reg, prod_i_next;
    logic signed [47:0] acc_reg, acc_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [35:0] y_reg, y_next;
    logic        [32:0] mant_reg, mant_next;
    logic signed [15:0] k_reg, k_next;
    logic        [48:0] eprod_reg, eprod_next;
    logic signed [47:0] s_reg, s_next;
    logic        [36:0] q1_reg, q1_next;
    logic        [16:0] r_reg, r_next;
    logic        [36:0] lam_reg, lam_next;
    logic        [51:0] t_reg, t_next;
    logic               fire_reg, fire_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               step_on;
    logic signed [16:0] veff;
    logic signed [32:0] md_prod;
    logic signed [49:0] pot_sum;
    logic signed [32:0] adp_prod;
    logic signed [49:0] adp_sum;
    logic signed [32:0] lin_prod;
    logic signed [51:0] y_prod;
    logic signed [26:0] ny;
    logic        [19:0] pw_frac;
    logic        [32:0] pw_mant;
    logic        [58:0] e_big;
    logic signed [16:0] rsh;
    logic        [46:0] e_term;
    logic signed [48:0] s_sum;
    logic signed [48:0] s_sat;
    logic        [46:0] n_val;
    logic        [63:0] q1_prod;
    logic        [46:0] q1k;
    logic        [34:0] q2p;
    logic        [6:0]  q2e;
    logic        [16:0] q2k;
    logic        [6:0]  q2;
    logic        [54:0] ly_prod;
    logic signed [16:0] nk;
    logic        [32:0] e32;
    logic        [32:0] p_val;
    logic signed [15:0] pot_out;
    logic signed [15:0] adp_out;

    assign step_on = (astep_reg != 16'sd0);
    assign veff    = step_on ? (17'(pot_reg) - 17'(adp_reg)) : 17'(pot_reg);

    assign md_prod  = $signed({1'b0, md_reg}) * pot_reg;
    assign pot_sum  = 50'(prod_i_reg) + (50'(md_prod) <<< 4) + (50'(jump_reg) <<< 20)
                    + 50'sd524288;
    assign adp_prod = $signed({1'b0, ad_reg}) * adp_reg;
    assign adp_sum  = 50'(adp_prod) + 50'sd32768;
    assign lin_prod = lrg_reg * veff;
    assign y_prod   = x_reg * $signed({1'b0, LOG2E_Q16});

    // one 2^x mantissa unit serves both the rate exponential and the escape probability
    assign ny      = -$signed({1'b0, t_reg[25:0]});
    assign pw_frac = cmd.prb2 ? ny[19:0] : y_reg[19:0];
    assign pw_mant = pow2_mant(pw_frac);

    // exponential term: scale by 2^(k-16), saturate
    assign rsh = 17'sd16 - 17'(k_reg);
    always_comb
    begin
        if (erg_reg == 16'd0)
            e_big = '0;
        else if (k_reg > 16'sd26)
            e_big = 59'(SAT_Q32);
        else if (k_reg >= 16'sd16)
            e_big = 59'(eprod_reg) << 4'(k_reg - 16'sd16);
        else if (rsh >= 17'sd63)
            e_big = '0;
        else
            e_big = 59'(eprod_reg >> rsh[5:0]);
    end
    assign e_term = (e_big > 59'(SAT_Q32)) ? SAT_Q32 : e_big[46:0];
    assign s_sum  = 49'(acc_reg) + $signed({2'b0, e_term});
    assign s_sat  = (s_sum > $signed({2'b0, SAT_Q32})) ? $signed({2'b0, SAT_Q32}) : s_sum;

    // lambda = (s + 500) / 1000: coarse reciprocal, then a small remainder pass
    assign n_val   = 47'(s_reg) + 47'd500;
    assign q1_prod = 64'(n_val[46:15]) * 64'(RECIP_Q41);
    assign q1k     = 47'(q1_reg) * 47'd1000;
    assign q2p     = 35'(r_reg) * 35'(RECIP_Q27);
    assign q2e     = 7'(q2p >> 27);
    assign q2k     = 17'(q2e) * 17'd1000;
    assign q2      = (q2k > r_reg) ? (q2e - 7'd1) : q2e;
    assign ly_prod = 55'(lam_reg) * 55'(LOG2E_Q16);

    assign nk  = -17'(k_reg);
    assign e32 = (nk >= 17'sd63) ? 33'd0 : (mant_reg >> nk[5:0]);
    always_comb
    begin
        if (status.lam_small)
            p_val = 33'(lam_reg[25:0]) - 33'(t_reg >> 33);
        else
            p_val = 33'h1_0000_0000 - e32;
    end

    assign pot_out = (fire_reg && RESET_ON_SPIKE) ? 16'sd0 : pot_reg;
    assign adp_out = (fire_reg && step_on) ? sat16(50'(adp_reg) + 50'(astep_reg)) : adp_reg;

    assign status.dead_zero = (dead_reg == 16'd0);
    assign status.rate_pos  = (s_sat > 49'sd0);
    assign status.lam_small = (lam_reg < SMALL_LAMBDA);
    assign status.out_busy  = out_valid_reg && !result.ready;

    assign cfg.ready      = 1'b1;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    always_comb
    begin
        md_next        = md_reg;
        ig_next        = ig_reg;
        ad_next        = ad_reg;
        astep_next     = astep_reg;
        lrg_next       = lrg_reg;
        erg_next       = erg_reg;
        slope_next     = slope_reg;
        dsteps_next    = dsteps_reg;
        pot_next       = pot_reg;
        adp_next       = adp_reg;
        held_next      = held_reg;
        dead_next      = dead_reg;
        jump_next      = jump_reg;
        cur_next       = cur_reg;
        rnd_next       = rnd_reg;
        prod_i_next    = prod_i_reg;
        acc_next       = acc_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        mant_next      = mant_reg;
        k_next         = k_reg;
        eprod_next     = eprod_reg;
        s_next         = s_reg;
        q1_next        = q1_reg;
        r_next         = r_reg;
        lam_next       = lam_reg;
        t_next         = t_reg;
        fire_next      = fire_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;

        if (cfg.valid)
        begin
            unique case (cfg.payload.reg_index)
                REG_MEMBRANE_DECAY:   md_next     = cfg.payload.wdata[15:0];
                REG_INPUT_GAIN:       ig_next     = cfg.payload.wdata;
                REG_ADAPT_DECAY:      ad_next     = cfg.payload.wdata[15:0];
                REG_ADAPT_STEP:       astep_next  = cfg.payload.wdata[15:0];
                REG_LINEAR_RATE_GAIN: lrg_next    = cfg.payload.wdata[15:0];
                REG_EXP_RATE_GAIN:    erg_next    = cfg.payload.wdata[15:0];
                REG_EXP_SLOPE:        slope_next  = cfg.payload.wdata[15:0];
                REG_DEAD_STEPS:       dsteps_next = cfg.payload.wdata[15:0];
                default: ;
            endcase
        end

        if (cmd.load)
        begin
            jump_next = item_payload.syn_jump;
            cur_next  = item_payload.input_current;
            rnd_next  = item_payload.random_uniform;
            fire_next = 1'b0;
        end
        if (cmd.mul_i)
            prod_i_next = $signed({1'b0, ig_reg}) * held_reg;
        if (cmd.pot)
            pot_next = sat16(pot_sum >>> 20);
        if (cmd.adp && step_on)
            adp_next = sat16(adp_sum >>> 16);
        if (cmd.lin)
            acc_next = 48'(lin_prod) <<< 8;
        if (cmd.expx)
            x_next = $signed({1'b0, slope_reg}) * veff;
        if (cmd.expy)
            y_next = 36'(y_prod >>> 16);
        if (cmd.expm)
        begin
            mant_next = pw_mant;
            k_next    = 16'(y_reg >>> 20);
        end
        if (cmd.expp)
            eprod_next = 49'(erg_reg) * 49'(mant_reg);
        if (cmd.exps)
            s_next = 48'(s_sat);
        if (cmd.div1)
            q1_next = 37'(q1_prod >> 26);
        if (cmd.div2)
            r_next = 17'(n_val - q1k);
        if (cmd.div3)
            lam_next = q1_reg + 37'(q2);
        if (cmd.prb1)
        begin
            if (status.lam_small)
                t_next = 52'(lam_reg[25:0]) * 52'(lam_reg[25:0]);
            else
                t_next = 52'(ly_prod >> 28);
        end
        if (cmd.prb2)
        begin
            mant_next = pw_mant;
            k_next    = 16'(ny >>> 20);
        end
        if (cmd.prb3)
            fire_next = ({1'b0, rnd_reg, 16'b0} <= p_val);

        if (cmd.commit)
        begin
            pot_next  = pot_out;
            adp_next  = adp_out;
            held_next = cur_reg;
            if (dead_reg == 16'd0)
                dead_next = fire_reg ? dsteps_reg : 16'd0;
            else
                dead_next = dead_reg - 16'd1;
            out_next.spike              = fire_reg;
            out_next.membrane_potential = pot_out;
            out_next.adapt_level        = adp_out;
            out_valid_next              = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            md_reg        <= 16'd65535;
            ig_reg        <= 24'd0;
            ad_reg        <= 16'd65535;
            astep_reg     <= 16'sd0;
            lrg_reg       <= 16'sd0;
            erg_reg       <= 16'd0;
            slope_reg     <= 16'd4096;
            dsteps_reg    <= 16'd10;
            pot_reg       <= 16'sd0;
            adp_reg       <= 16'sd0;
            held_reg      <= 24'sd0;
            dead_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            md_reg        <= md_next;
            ig_reg        <= ig_next;
            ad_reg        <= ad_next;
            astep_reg     <= astep_next;
            lrg_reg       <= lrg_next;
            erg_reg       <= erg_next;
            slope_reg     <= slope_next;
            dsteps_reg    <= dsteps_next;
            pot_reg       <= pot_next;
            adp_reg       <= adp_next;
            held_reg      <= held_next;
            dead_reg      <= dead_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        jump_reg   <= jump_next;
        cur_reg    <= cur_next;
        rnd_reg    <= rnd_next;
        prod_i_reg <= prod_i_next;
        acc_reg    <= acc_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        mant_reg   <= mant_next;
        k_reg      <= k_next;
        eprod_reg  <= eprod_next;
        s_reg      <= s_next;
        q1_reg     <= q1_next;
        r_reg      <= r_next;
        lam_reg    <= lam_next;
        t_reg      <= t_next;
        fire_reg   <= fire_next;
        out_reg    <= out_next;
    end

endmodule

FILE: rtl/escape_noise_spiking_neuron_core.sv
// channel   dir  beat payload                                         accepted when
// item      in   syn_jump, input_current, random_uniform             item.valid & item.ready
// result    out  spike, membrane_potential, adapt_level              result.valid & result.ready
// cfg       in   reg_index, wdata                                    cfg.valid & cfg.ready
//
// One item at a time through a sequencer over a registered datapath. An item runs load, input
// multiply, potential and adaptation steps and ends there in dead time; else linear and 2^x rate
// steps follow, ending when the rate is not positive; else divide by 1000 and escape probability
// steps, with a second 2^x step unless lambda is small, before the final state.
// The result sits in an output register, so the next item is taken while it waits; a
// stall holds the sequencer only when a second result is ready. cfg is always ready.
// rst_n clears the neuron state and loads the register reset values; no clearing pass.
module escape_noise_spiking_neuron_core #(
    parameter bit RESET_ON_SPIKE = 1'b1
) (
    input  logic         clk,
    input  logic         rst_n,
    esn_item_if.sink     item,
    esn_result_if.source result,
    esn_cfg_if.sink      cfg
);
    import esn_pkg::*;

    cmd_t    cmd;
    status_t status;

    esn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    esn_datapath #(
        .RESET_ON_SPIKE (RESET_ON_SPIKE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item_payload (item.payload),
        .cfg          (cfg),
        .result       (result)
    );

endmodule

FILE: rtl/esn_checker.sv
module esn_checker #(
    parameter bit RESET_ON_SPIKE = 1'b1
) (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input esn_pkg::result_t out_payload
);
    import esn_pkg::*;

    // one item in flight: the input side closes right after a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped under stall");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_payload))
        else $error("result changed under stall");

    a_spike_resets: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.spike && RESET_ON_SPIKE |->
            out_payload.membrane_potential == 16'sd0)
        else $error("potential not cleared on spike");

endmodule

bind escape_noise_spiking_neuron_core esn_checker #(
    .RESET_ON_SPIKE (RESET_ON_SPIKE)
) u_esn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (item.valid),
    .in_ready    (item.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_payload (result.payload)
);
